// ===== hw/rtl/waveform_lod_line_decimator_defines.svh =====
// Assertion macros for the line decimator.
`ifndef WAVEFORM_LOD_LINE_DECIMATOR_DEFINES_SVH
`define WAVEFORM_LOD_LINE_DECIMATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define WLD_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a condition is followed in the next cycle by another.
`define WLD_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`else

`define WLD_ASSERT_ALWAYS(lbl, expr, msg)
`define WLD_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ===== hw/rtl/wld_pkg.sv =====
package wld_pkg;

   // Fixed field widths.
   localparam int SAMPLE_W = 16;
   localparam int LEVEL_W  = 8;
   localparam int FLAGS_W  = 8;
   localparam int STRIDE_W = 13;
   localparam int WEIGHT_W = 16;   // |-32768| = 32768 still fits unsigned
   localparam int PROD_W   = LEVEL_W + WEIGHT_W;
   localparam int NUM_LVL  = 4;

   localparam logic [FLAGS_W-1:0] FLAGS_ALL_ONES = '1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] line_minimum;
      logic signed [SAMPLE_W-1:0] line_maximum;
      logic [LEVEL_W-1:0]         line_rms;
      logic [LEVEL_W-1:0]         line_bass;
      logic [LEVEL_W-1:0]         line_mid;
      logic [LEVEL_W-1:0]         line_treble;
      logic [FLAGS_W-1:0]         line_flags;
      logic                       end_of_track;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_minimum;
      logic signed [SAMPLE_W-1:0] out_maximum;
      logic [LEVEL_W-1:0]         out_rms;
      logic [LEVEL_W-1:0]         out_bass;
      logic [LEVEL_W-1:0]         out_mid;
      logic [LEVEL_W-1:0]         out_treble;
      logic [FLAGS_W-1:0]         out_flags;
   } rsp_type;

endpackage

// ===== hw/rtl/wld_alu.sv =====
// Shared add / subtract unit with borrow out.
module wld_alu import wld_pkg::*; #(
   parameter int WIDTH = 36
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   input  logic             op_sub,
   output logic [WIDTH-1:0] result,
   output logic             borrow
);

   logic [WIDTH:0] full;

   always_comb begin
      if (op_sub) begin
         full = {1'b0, op_a} - {1'b0, op_b};
      end else begin
         full = {1'b0, op_a} + {1'b0, op_b};
      end
   end

   assign result = full[WIDTH-1:0];
   assign borrow = op_sub & full[WIDTH];

endmodule

// ===== hw/rtl/wld_weight.sv =====
// Line weight: max(1, |min|, |max|).
module wld_weight import wld_pkg::*; (
   input  logic signed [SAMPLE_W-1:0] line_minimum,
   input  logic signed [SAMPLE_W-1:0] line_maximum,
   output logic [WEIGHT_W-1:0]        weight
);

   logic [WEIGHT_W-1:0] mag_min;
   logic [WEIGHT_W-1:0] mag_max;
   logic [WEIGHT_W-1:0] mag_big;

   always_comb begin
      mag_min = line_minimum[SAMPLE_W-1] ? WEIGHT_W'(-line_minimum) : WEIGHT_W'(line_minimum);
      mag_max = line_maximum[SAMPLE_W-1] ? WEIGHT_W'(-line_maximum) : WEIGHT_W'(line_maximum);
      mag_big = (mag_max > mag_min) ? mag_max : mag_min;
      weight  = (mag_big == '0) ? WEIGHT_W'(1) : mag_big;
   end

endmodule

// ===== hw/rtl/waveform_lod_line_decimator.sv =====
// Waveform level-of-detail line decimator.
// Input channel req_*: one display line per word (min, max, four levels, flags,
// end_of_track). Result channel rsp_*: one folded line per closed group. Both
// use valid / stall; a word moves on a clock edge with valid high, stall low.
// csr_write_enable / csr_write_data set group_stride (0 acts as 1, values above
// MAX_STRIDE saturate). Write it only while the block is idle.
// Sequence: a line passes through accept, four multiply-accumulate steps on
// the shared adder and a final add. A line that closes its group then runs
// restoring division (4 levels x 8 quotient bits, one bit per cycle on the same
// adder) and an output step that loads the result register. The block takes
// no new line until it is back in idle.
// The result register lets a finished word wait while new lines are taken; only
// when a second group closes before the first word is taken does the block hold
// in its output step and keep req_stall high.
// Reset (synchronous, active high) empties the open group, drops any pending
// result word and sets group_stride to 1.
`include "waveform_lod_line_decimator_defines.svh"

module waveform_lod_line_decimator import wld_pkg::*; #(
   parameter int MAX_STRIDE = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_write_enable,
   input  logic [STRIDE_W-1:0] csr_write_data
);

   // Weight sum: each line adds at most 2^15.
   localparam int WSUM_W = (WEIGHT_W - 1) + $clog2(MAX_STRIDE + 1);
   localparam int LSUM_W = WSUM_W + LEVEL_W;
   localparam logic [STRIDE_W-1:0] STRIDE_CAP = STRIDE_W'(MAX_STRIDE);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL0 = 3'd1;
   localparam logic [2:0] ST_MUL1 = 3'd2;
   localparam logic [2:0] ST_MUL2 = 3'd3;
   localparam logic [2:0] ST_MUL3 = 3'd4;
   localparam logic [2:0] ST_ACC  = 3'd5;
   localparam logic [2:0] ST_DIV  = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   localparam logic [2:0] BIT_TOP = 3'd7;
   localparam logic [1:0] LVL_LAST = 2'(NUM_LVL - 1);

   // Control state.
   logic [2:0]          state_ff, state_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic                close_ff, close_in;
   logic [1:0]          chan_ff, chan_in;
   logic [2:0]          bit_ff, bit_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Group state.
   logic [STRIDE_W-1:0]        cnt_ff, cnt_in;
   logic signed [SAMPLE_W-1:0] run_min_ff, run_min_in;
   logic signed [SAMPLE_W-1:0] run_max_ff, run_max_in;
   logic [FLAGS_W-1:0]         flags_ff, flags_in;
   logic [WSUM_W-1:0]          wsum_ff, wsum_in;
   logic [LSUM_W-1:0]          lsum_ff [NUM_LVL];
   logic [LSUM_W-1:0]          lsum_in [NUM_LVL];

   // Working registers.
   logic [LEVEL_W-1:0]  lvl_ff [NUM_LVL];
   logic [LEVEL_W-1:0]  lvl_in [NUM_LVL];
   logic [WEIGHT_W-1:0] w_ff, w_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [LSUM_W-1:0]   rem_ff, rem_in;
   logic [LEVEL_W-1:0]  quo_ff, quo_in;
   logic [LEVEL_W-1:0]  res_ff [NUM_LVL];
   logic [LEVEL_W-1:0]  res_in [NUM_LVL];
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [WEIGHT_W-1:0] line_weight;
   logic [STRIDE_W-1:0] stride_eff;
   logic [STRIDE_W-1:0] cnt_next;
   logic [1:0]          mul_idx;
   logic [LSUM_W-1:0]   alu_a, alu_b, alu_res;
   logic                alu_sub, alu_borrow;
   logic                req_take, out_write, q_bit;
   logic [LEVEL_W-1:0]  quo_next;

   wld_weight u_weight (
      .line_minimum (req_data.line_minimum),
      .line_maximum (req_data.line_maximum),
      .weight       (line_weight)
   );

   wld_alu #(
      .WIDTH (LSUM_W)
   ) u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .op_sub (alu_sub),
      .result (alu_res),
      .borrow (alu_borrow)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign out_write = (state_ff == ST_OUT) & (~rsp_valid_ff | ~rsp_stall);

   // Clamp the stride: zero counts as one, saturate at the cap.
   always_comb begin
      if (stride_ff == '0) begin
         stride_eff = STRIDE_W'(1);
      end else if (32'(stride_ff) > MAX_STRIDE) begin
         stride_eff = STRIDE_CAP;
      end else begin
         stride_eff = stride_ff;
      end
   end

   assign cnt_next = cnt_ff + STRIDE_W'(1);

   // Level fed to the multiplier in each step.
   always_comb begin
      case (state_ff)
         ST_MUL1: mul_idx = 2'd1;
         ST_MUL2: mul_idx = 2'd2;
         ST_MUL3: mul_idx = 2'd3;
         default: mul_idx = 2'd0;
      endcase
   end

   // Operand select for the shared adder.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         ST_MUL0: begin
            alu_a = LSUM_W'(wsum_ff);
            alu_b = LSUM_W'(w_ff);
         end
         ST_MUL1: begin
            alu_a = lsum_ff[0];
            alu_b = LSUM_W'(prod_ff);
         end
         ST_MUL2: begin
            alu_a = lsum_ff[1];
            alu_b = LSUM_W'(prod_ff);
         end
         ST_MUL3: begin
            alu_a = lsum_ff[2];
            alu_b = LSUM_W'(prod_ff);
         end
         ST_ACC: begin
            alu_a = lsum_ff[3];
            alu_b = LSUM_W'(prod_ff);
         end
         ST_DIV: begin
            // Start each level from its sum, then work on the remainder.
            alu_a   = (bit_ff == BIT_TOP) ? lsum_ff[chan_ff] : rem_ff;
            alu_b   = LSUM_W'(wsum_ff) << bit_ff;
            alu_sub = 1'b1;
         end
         default: begin
            alu_sub = 1'b0;
         end
      endcase
   end

   assign q_bit    = ~alu_borrow;
   assign quo_next = {quo_ff[LEVEL_W-2:0], q_bit};

   always_comb begin
      state_in     = state_ff;
      stride_in    = stride_ff;
      close_in     = close_ff;
      chan_in      = chan_ff;
      bit_in       = bit_ff;
      cnt_in       = cnt_ff;
      run_min_in   = run_min_ff;
      run_max_in   = run_max_ff;
      flags_in     = flags_ff;
      wsum_in      = wsum_ff;
      lsum_in      = lsum_ff;
      lvl_in       = lvl_ff;
      w_in         = w_ff;
      prod_in      = lvl_ff[mul_idx] * w_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      if (csr_write_enable) begin
         stride_in = csr_write_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // Fold min, max, flags and count now; the sums follow.
               if (cnt_ff == '0) begin
                  run_min_in = req_data.line_minimum;
                  run_max_in = req_data.line_maximum;
               end else begin
                  if ($signed(req_data.line_minimum) < run_min_ff) begin
                     run_min_in = req_data.line_minimum;
                  end
                  if ($signed(req_data.line_maximum) > run_max_ff) begin
                     run_max_in = req_data.line_maximum;
                  end
               end
               flags_in  = flags_ff & req_data.line_flags;
               cnt_in    = cnt_next;
               close_in  = (cnt_next >= stride_eff) | req_data.end_of_track;
               w_in      = line_weight;
               lvl_in[0] = req_data.line_rms;
               lvl_in[1] = req_data.line_bass;
               lvl_in[2] = req_data.line_mid;
               lvl_in[3] = req_data.line_treble;
               state_in  = ST_MUL0;
            end
         end
         ST_MUL0: begin
            wsum_in  = alu_res[WSUM_W-1:0];
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            lsum_in[0] = alu_res;
            state_in   = ST_MUL2;
         end
         ST_MUL2: begin
            lsum_in[1] = alu_res;
            state_in   = ST_MUL3;
         end
         ST_MUL3: begin
            lsum_in[2] = alu_res;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            lsum_in[3] = alu_res;
            if (close_ff) begin
               chan_in  = '0;
               bit_in   = BIT_TOP;
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            // One restoring step: keep the difference when it does not borrow.
            rem_in = q_bit ? alu_res : alu_a;
            quo_in = quo_next;
            if (bit_ff == '0) begin
               res_in[chan_ff] = quo_next;
               bit_in          = BIT_TOP;
               if (chan_ff == LVL_LAST) begin
                  state_in = ST_OUT;
               end else begin
                  chan_in = chan_ff + 2'd1;
               end
            end else begin
               bit_in = bit_ff - 3'd1;
            end
         end
         ST_OUT: begin
            if (out_write) begin
               rsp_data_in.out_minimum = run_min_ff;
               rsp_data_in.out_maximum = run_max_ff;
               rsp_data_in.out_rms     = res_ff[0];
               rsp_data_in.out_bass    = res_ff[1];
               rsp_data_in.out_mid     = res_ff[2];
               rsp_data_in.out_treble  = res_ff[3];
               rsp_data_in.out_flags   = flags_ff;
               rsp_valid_in            = 1'b1;
               // Empty the group for the next line.
               cnt_in     = '0;
               run_min_in = '0;
               run_max_in = '0;
               flags_in   = FLAGS_ALL_ONES;
               wsum_in    = '0;
               for (int i = 0; i < NUM_LVL; i++) begin
                  lsum_in[i] = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stride_ff    <= STRIDE_W'(1);
         close_ff     <= 1'b0;
         chan_ff      <= '0;
         bit_ff       <= BIT_TOP;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         run_min_ff   <= '0;
         run_max_ff   <= '0;
         flags_ff     <= FLAGS_ALL_ONES;
         wsum_ff      <= '0;
         for (int i = 0; i < NUM_LVL; i++) begin
            lsum_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         stride_ff    <= stride_in;
         close_ff     <= close_in;
         chan_ff      <= chan_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         run_min_ff   <= run_min_in;
         run_max_ff   <= run_max_in;
         flags_ff     <= flags_in;
         wsum_ff      <= wsum_in;
         lsum_ff      <= lsum_in;
      end
   end

   // Datapath registers: no reset.
   always_ff @(posedge clock) begin
      lvl_ff      <= lvl_in;
      w_ff        <= w_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A taken line always starts the multiply-accumulate steps.
   `WLD_ASSERT_NEXT(a_take_starts_mac, req_take, state_ff == ST_MUL0, "line taken but MAC not started")

   // Division only runs on a group that holds weight.
   `WLD_ASSERT_ALWAYS(a_div_nonzero, (state_ff != ST_DIV) || (wsum_ff != '0), "divide by zero weight")

   // Loading the result word empties the group and raises valid.
   `WLD_ASSERT_NEXT(a_out_clears, out_write, (cnt_ff == '0) && (wsum_ff == '0) && rsp_valid_ff, "group not emptied after result")

endmodule

// ===== sim/waveform_lod_line_decimator_tb.sv =====
`timescale 1ns / 1ps

module waveform_lod_line_decimator_tb;
   import wld_pkg::*;

   // Stride ceiling of the instance; the shadow saturates to the same value.
   localparam int LINE_LIMIT    = 4096;
   // Idle time to let the block finish a line, whether or not it closes a
   // group, with margin, before the stride register is touched.
   localparam int SETTLE_CYCLES = 60;
   localparam int RANDOM_LINES  = 450;
   // Lines in the long max-weight group.
   localparam int FULL_LINES    = 1024;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   req_type             req_data         = '0;
   logic                rsp_stall        = 1'b0;
   logic                csr_write_enable = 1'b0;
   logic [STRIDE_W-1:0] csr_write_data   = '0;
   logic                req_stall;
   logic                rsp_valid;
   rsp_type             rsp_data;

   waveform_lod_line_decimator #(
      .MAX_STRIDE(LINE_LIMIT)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow of the stride register and of the open group.
   logic [STRIDE_W-1:0]        stride_shadow = 13'd1;
   logic [STRIDE_W-1:0]        lines_held;
   logic signed [SAMPLE_W-1:0] low_so_far;
   logic signed [SAMPLE_W-1:0] high_so_far;
   longint unsigned            level_acc [NUM_LVL];
   longint unsigned            weight_acc;
   logic [FLAGS_W-1:0]         flags_acc;

   // Folded lines still owed by the block, oldest first.
   rsp_type folded_lines[$];

   int mismatches  = 0;
   // Sender pacing: bursts of words separated by idle gaps when gaps_on is set.
   bit gaps_on     = 1'b0;
   int burst_left  = 0;
   // Receiver pattern: 0 never stalls, 1 stalls at random, 2 long stall runs.
   int stall_mode  = 0;
   int stall_run   = 0;

   function automatic void clear_group();
      lines_held  = '0;
      low_so_far  = '0;
      high_so_far = '0;
      foreach (level_acc[k]) level_acc[k] = 0;
      weight_acc  = 0;
      flags_acc   = FLAGS_ALL_ONES;
   endfunction

   // Fold one accepted line into the open group; queue the folded line when
   // the group closes on its count or on end_of_track.
   function automatic void fold_line(req_type ln);
      int                 mag_lo;
      int                 mag_hi;
      int                 weight;
      int unsigned        limit;
      longint unsigned    divisor;
      logic [LEVEL_W-1:0] lvl [NUM_LVL];
      rsp_type            folded;
      lvl[0] = ln.line_rms;
      lvl[1] = ln.line_bass;
      lvl[2] = ln.line_mid;
      lvl[3] = ln.line_treble;
      // Zero acts as one, anything past the ceiling saturates.
      limit = stride_shadow;
      if (limit == 0) limit = 1;
      if (limit > LINE_LIMIT) limit = LINE_LIMIT;
      if (lines_held == 0) begin
         low_so_far  = ln.line_minimum;
         high_so_far = ln.line_maximum;
      end else begin
         if (ln.line_minimum < low_so_far) low_so_far = ln.line_minimum;
         if (ln.line_maximum > high_so_far) high_so_far = ln.line_maximum;
      end
      // Weight is max(1, |min|, |max|); |-32768| stays 32768 in an int.
      mag_lo = ln.line_minimum;
      mag_hi = ln.line_maximum;
      if (mag_lo < 0) mag_lo = -mag_lo;
      if (mag_hi < 0) mag_hi = -mag_hi;
      weight = (mag_hi > mag_lo) ? mag_hi : mag_lo;
      if (weight < 1) weight = 1;
      for (int k = 0; k < NUM_LVL; k++) level_acc[k] += longint'(lvl[k]) * weight;
      weight_acc += weight;
      flags_acc  &= ln.line_flags;
      lines_held  = lines_held + 1'b1;
      if (lines_held >= limit || ln.end_of_track) begin
         divisor            = (weight_acc != 0) ? weight_acc : 1;
         folded.out_minimum = low_so_far;
         folded.out_maximum = high_so_far;
         folded.out_rms     = 8'(level_acc[0] / divisor);
         folded.out_bass    = 8'(level_acc[1] / divisor);
         folded.out_mid     = 8'(level_acc[2] / divisor);
         folded.out_treble  = 8'(level_acc[3] / divisor);
         folded.out_flags   = flags_acc;
         folded_lines       = {folded_lines, folded};
         clear_group();
      end
   endfunction

   function automatic req_type make_line(int lo, int hi, int rms, int bass, int mid,
                                         int treble, int flags, bit eot);
      req_type ln;
      ln.line_minimum = 16'(lo);
      ln.line_maximum = 16'(hi);
      ln.line_rms     = 8'(rms);
      ln.line_bass    = 8'(bass);
      ln.line_mid     = 8'(mid);
      ln.line_treble  = 8'(treble);
      ln.line_flags   = 8'(flags);
      ln.end_of_track = eot;
      return ln;
   endfunction

   // Bias samples toward the rails, zero and tiny magnitudes.
   function automatic int random_sample();
      case ($urandom_range(0, 7))
         0:       return -32768;
         1:       return 32767;
         2:       return 0;
         3:       return int'($urandom_range(0, 6)) - 3;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   function automatic int random_level();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // Mostly ordered min <= max; the rest go in as drawn, min above max too.
   function automatic req_type random_line(int eot_odds);
      int a;
      int b;
      int flags;
      a = random_sample();
      b = random_sample();
      if ($urandom_range(0, 6) != 0 && a > b) begin
         a = a ^ b;
         b = a ^ b;
         a = a ^ b;
      end
      // Keep most flag bytes dense so the AND does not collapse at once.
      case ($urandom_range(0, 3))
         0:       flags = $urandom_range(0, 255);
         1:       flags = 8'hff;
         default: flags = 8'hff ^ (1 << $urandom_range(0, 7));
      endcase
      return make_line(a, b, random_level(), random_level(), random_level(),
                       random_level(), flags, $urandom_range(1, eot_odds) == 1);
   endfunction

   // Hold the word until the edge that takes it, then fold it into the shadow.
   task automatic send_line(req_type ln);
      int gap;
      req_valid <= 1'b1;
      req_data  <= ln;
      do @(posedge clock); while (req_stall);
      fold_line(ln);
      if (gaps_on) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            // Mix short gaps with ones that span the whole division.
            gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 45)
                                                     : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drop valid, wait for every owed word, then let the block go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (folded_lines.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_stride(logic [STRIDE_W-1:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      stride_shadow     = value;
   endtask

   // Stride 1 out of reset: every line closes its own group.
   task automatic test_reset_stride();
      gaps_on    = 1'b0;
      stall_mode = 0;
      send_line(make_line(-32768, 32767, 255, 255, 255, 255, 8'hff, 1'b0));
      // Zero magnitude still weighs one.
      send_line(make_line(0, 0, 0, 0, 0, 0, 8'h00, 1'b0));
      send_line(make_line(-32768, -32768, 1, 2, 3, 4, 8'h5a, 1'b1));
   endtask

   // Zero stride acts as one; strides past the ceiling saturate.
   task automatic test_stride_limits();
      write_stride(13'd0);
      send_line(make_line(-5, 7, 10, 20, 30, 40, 8'hf0, 1'b0));
      send_line(make_line(100, -100, 200, 100, 50, 25, 8'h0f, 1'b0));
      write_stride(13'h1fff);
      send_line(make_line(-1, 1, 255, 0, 255, 0, 8'hff, 1'b0));
      send_line(make_line(32767, 32767, 0, 255, 0, 255, 8'h7e, 1'b0));
      send_line(make_line(-32768, 0, 128, 128, 128, 128, 8'hbd, 1'b1));
      write_stride(13'd4097);
      send_line(make_line(-300, 300, 9, 9, 9, 9, 8'hff, 1'b1));
   endtask

   // Stride changes under an open group: the group stays and closes on the first
   // line that brings its count to or past the new stride.
   task automatic test_stride_change();
      write_stride(13'd8);
      repeat (5) send_line(random_line(1000000));
      write_stride(13'd3);
      send_line(make_line(-2, 2, 17, 34, 51, 68, 8'hff, 1'b0));
      write_stride(13'd2);
      send_line(make_line(-1000, 1000, 200, 0, 100, 50, 8'hee, 1'b0));
      write_stride(13'd5);
      send_line(make_line(3, 3, 1, 1, 1, 1, 8'hdd, 1'b0));
      send_line(make_line(-4, 4, 2, 2, 2, 2, 8'hcc, 1'b0));
      send_line(make_line(5, 6, 3, 3, 3, 3, 8'hbb, 1'b0));
   endtask

   // end_of_track closes a partial group, also on its first line.
   task automatic test_end_of_track();
      write_stride(13'd5);
      send_line(make_line(-7, 9, 11, 22, 33, 44, 8'hf3, 1'b0));
      send_line(make_line(-9, 7, 44, 33, 22, 11, 8'h3f, 1'b1));
      send_line(make_line(12, 40, 250, 5, 125, 60, 8'h81, 1'b1));
   endtask

   // One long group with the largest weight on every line, so the sums
   // grow wide.
   task automatic test_full_group();
      req_type ln;
      write_stride(STRIDE_W'(FULL_LINES));
      gaps_on    = 1'b0;
      stall_mode = 1;
      for (int k = 0; k < FULL_LINES; k++) begin
         ln              = random_line(1000000);
         ln.line_minimum = 16'h8000;
         ln.end_of_track = 1'b0;
         if (k < 8) begin
            ln.line_rms    = 8'hff;
            ln.line_bass   = 8'hff;
            ln.line_mid    = 8'hff;
            ln.line_treble = 8'hff;
         end
         send_line(ln);
      end
   endtask

   // Phases of random lines, each under its own stride and pacing. Open
   // groups are carried across the stride writes on purpose.
   task automatic test_random();
      int sent;
      int phase_lines;
      int eot_odds;
      logic [STRIDE_W-1:0] stride;
      sent = 0;
      while (sent < RANDOM_LINES) begin
         case ($urandom_range(0, 11))
            0:       stride = 13'd0;
            1:       stride = 13'($urandom_range(4097, 8191));
            2:       stride = 13'd4096;
            3:       stride = 13'($urandom_range(40, 400));
            default: stride = 13'($urandom_range(1, 12));
         endcase
         write_stride(stride);
         phase_lines = $urandom_range(10, 80);
         eot_odds    = $urandom_range(4, 40);
         gaps_on     = ($urandom_range(0, 3) != 0);
         stall_mode  = $urandom_range(0, 2);
         burst_left  = 0;
         repeat (phase_lines) send_line(random_line(eot_odds));
         sent += phase_lines;
      end
   endtask

   // Receiver stall pattern, fresh every edge.
   always @(posedge clock) begin
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: begin
            if (stall_run > 0) begin
               stall_run <= stall_run - 1;
            end else begin
               rsp_stall <= !rsp_stall;
               stall_run <= rsp_stall ? $urandom_range(1, 30) : $urandom_range(1, 50);
            end
         end
      endcase
   end

   // Check every taken result word against the oldest folded line.
   always @(posedge clock) begin : check_words
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (folded_lines.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: min %0d max %0d lvl %0d %0d %0d %0d flags %h",
                        rsp_data.out_minimum, rsp_data.out_maximum, rsp_data.out_rms,
                        rsp_data.out_bass, rsp_data.out_mid, rsp_data.out_treble,
                        rsp_data.out_flags);
         end else begin
            want = folded_lines.pop_front();
            if (rsp_data.out_minimum !== want.out_minimum ||
                rsp_data.out_maximum !== want.out_maximum ||
                rsp_data.out_rms     !== want.out_rms     ||
                rsp_data.out_bass    !== want.out_bass    ||
                rsp_data.out_mid     !== want.out_mid     ||
                rsp_data.out_treble  !== want.out_treble  ||
                rsp_data.out_flags   !== want.out_flags) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at %0t: expected min %0d max %0d lvl %0d %0d %0d %0d flags %h",
                           $realtime, want.out_minimum, want.out_maximum, want.out_rms,
                           want.out_bass, want.out_mid, want.out_treble, want.out_flags);
                  $display("                     got min %0d max %0d lvl %0d %0d %0d %0d flags %h",
                           rsp_data.out_minimum, rsp_data.out_maximum, rsp_data.out_rms,
                           rsp_data.out_bass, rsp_data.out_mid, rsp_data.out_treble,
                           rsp_data.out_flags);
               end
            end
         end
      end
   end

   initial begin
      clear_group();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_stride();
      test_stride_limits();
      test_stride_change();
      test_end_of_track();
      test_full_group();
      test_random();
      // Drain every owed word and let the last line finish.
      settle();
      if (mismatches == 0 && folded_lines.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Bound the run well past the slowest legal schedule.
   initial begin
      #8ms;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/wld_pkg.sv
hw/rtl/wld_alu.sv
hw/rtl/wld_weight.sv
hw/rtl/waveform_lod_line_decimator.sv
sim/waveform_lod_line_decimator_tb.sv
